@@ hw/rtl/lpht_pkg.sv @@
// shared constants and types for the linear probing hash table
`timescale 1ns / 1ps

package lpht_pkg;

	// table geometry
	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int IDX_W     = SLOT_W + 1;

	// field widths
	localparam int KEY_W    = 32;
	localparam int SIZE_W   = 9;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 8;
	localparam int OUT_W    = 16;

	// reset value of the size register
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SLOTS);

	// request kinds carried in tuser
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED     = 3'd0,
		ST_DUPLICATE    = 3'd1,
		ST_NO_SPACE     = 3'd2,
		ST_FOUND        = 3'd3,
		ST_ABSENT_EMPTY = 3'd4,
		ST_ABSENT_END   = 3'd5
	} status_t;

endpackage

@@ hw/rtl/lpht_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hw/rtl/lpht_mod.sv @@
// bit serial remainder of a key by the table size
`timescale 1ns / 1ps

module lpht_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpht_pkg::KEY_W-1:0]        dividend,
	input  logic [lpht_pkg::SIZE_W-1:0]       divisor,
	output logic                              done,
	output logic [lpht_pkg::SLOT_W-1:0]       remainder
);

	localparam int CNT_W = $clog2(lpht_pkg::KEY_W);

	logic                              busy_q;
	logic                              done_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [lpht_pkg::KEY_W-1:0]        shift_q;
	logic [lpht_pkg::SIZE_W-1:0]       div_q;
	logic [lpht_pkg::SLOT_W-1:0]       rem_q;
	logic [lpht_pkg::SLOT_W:0]         trial;
	logic [lpht_pkg::SLOT_W:0]         next_rem;

	// one restoring step: bring in the next key bit, subtract when it fits
	always_comb begin
		trial = {rem_q, shift_q[lpht_pkg::KEY_W-1]};
		if (trial >= div_q) begin
			next_rem = trial - div_q;
		end else begin
			next_rem = trial;
		end
	end

	// step sequencer, key bits from the top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				shift_q <= dividend;
				div_q   <= divisor;
				rem_q   <= '0;
			end else if (busy_q) begin
				shift_q <= {shift_q[lpht_pkg::KEY_W-2:0], 1'b0};
				rem_q   <= next_rem[lpht_pkg::SLOT_W-1:0];
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(lpht_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/linear_probe_hash_table.sv @@
// top level of the linear probing hash table
`timescale 1ns / 1ps

// Open addressing hash table of 32-bit keys, 256 slots, linear probing upward
// without wrap. Input items arrive on s_tvalid/s_tready: s_tdata holds the
// key, s_tuser selects insert (0) or search (1). Each item gives one result on
// m_tvalid/m_tready: m_tdata holds status and slot position.
// The cfg channel writes table_size (always ready); it sets both the hash
// modulus and the probe end, 0 acts as 1 and anything above 256 as 256.
// Work per item, in order: the key remainder through a bit-serial divider
// (32 steps and a handoff), a slot bound and valid check per slot, a key
// compare per occupied slot (registered memory read), then the load of the
// output register. s_tready returns with that load.
// Only one item is worked on at a time, and s_tready is low meanwhile.
// The output register holds a finished result while m_tready is low; a new
// item may be accepted then, and its result waits until the register frees.
// Reset clears all slot valid bits at once (every slot empty) and sets
// table_size to 256; the slot key memory is not cleared.
module linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: table_size
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // key
	input  logic [0:0]  s_tuser,   // mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // status[2:0], position[10:3], zero fill
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_CMP,
		S_RESP
	} state_t;

	state_t                            state_q;
	logic [lpht_pkg::SIZE_W-1:0]       size_q;
	logic [lpht_pkg::SIZE_W-1:0]       eff_size;
	logic                              mode_q;
	logic [lpht_pkg::KEY_W-1:0]        key_q;
	logic [lpht_pkg::IDX_W-1:0]        idx_q;
	logic [lpht_pkg::MAX_SLOTS-1:0]    valid_q;
	lpht_pkg::status_t                 status_q;
	logic [lpht_pkg::POS_W-1:0]        pos_q;
	logic                              out_valid_q;
	lpht_pkg::status_t                 out_status_q;
	logic [lpht_pkg::POS_W-1:0]        out_pos_q;

	logic                              in_fire;
	logic                              resp_load;
	logic                              mod_done;
	logic [lpht_pkg::SLOT_W-1:0]       mod_rem;
	logic [lpht_pkg::SLOT_W-1:0]       slot;
	logic                              ram_wr;
	logic [lpht_pkg::KEY_W-1:0]        ram_rd_data;

	// clamp the configured size into 1..MAX_SLOTS
	always_comb begin
		if (size_q == '0) begin
			eff_size = lpht_pkg::SIZE_W'(1);
		end else if (size_q > lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS)) begin
			eff_size = lpht_pkg::SIZE_W'(lpht_pkg::MAX_SLOTS);
		end else begin
			eff_size = size_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign slot      = idx_q[lpht_pkg::SLOT_W-1:0];

	// finished result moves into a free or draining output register
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || m_tready);

	// store the key into an empty slot on insert
	assign ram_wr = (state_q == S_PROBE) && (idx_q < eff_size) && !valid_q[slot]
		&& (mode_q == lpht_pkg::MODE_INSERT);

	// home slot computation
	lpht_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_fire),
		.dividend  (s_tdata),
		.divisor   (eff_size),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	// slot key storage
	lpht_ram #(
		.WIDTH (lpht_pkg::KEY_W),
		.DEPTH (lpht_pkg::MAX_SLOTS)
	) u_keys (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (slot),
		.wr_data (key_q),
		.rd_addr (slot),
		.rd_data (ram_rd_data)
	);

	// sequencer, valid bits and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= lpht_pkg::SIZE_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			// output register: load a finished result, drop a taken one
			if (resp_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= status_q;
				out_pos_q    <= pos_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						mode_q  <= s_tuser[0];
						key_q   <= s_tdata;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_done) begin
						idx_q   <= {1'b0, mod_rem};
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (idx_q >= eff_size) begin
						// walked off the end of the table
						status_q <= (mode_q == lpht_pkg::MODE_SEARCH) ?
							lpht_pkg::ST_ABSENT_END : lpht_pkg::ST_NO_SPACE;
						pos_q    <= '0;
						state_q  <= S_RESP;
					end else if (!valid_q[slot]) begin
						// empty slot ends the walk
						if (mode_q == lpht_pkg::MODE_SEARCH) begin
							status_q <= lpht_pkg::ST_ABSENT_EMPTY;
							pos_q    <= '0;
						end else begin
							valid_q[slot] <= 1'b1;
							status_q      <= lpht_pkg::ST_INSERTED;
							pos_q         <= lpht_pkg::POS_W'(slot);
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (ram_rd_data == key_q) begin
						if (mode_q == lpht_pkg::MODE_SEARCH) begin
							status_q <= lpht_pkg::ST_FOUND;
							pos_q    <= lpht_pkg::POS_W'(slot);
						end else begin
							status_q <= lpht_pkg::ST_DUPLICATE;
							pos_q    <= '0;
						end
						state_q <= S_RESP;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_PROBE;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		(lpht_pkg::OUT_W - lpht_pkg::POS_W - lpht_pkg::STATUS_W)'(0),
		out_pos_q,
		out_status_q
	};

endmodule

@@ tb/sv/lpht_checker.sv @@
// result checker for the linear probing hash table testbench
`timescale 1ns / 1ps

module lpht_checker
	import lpht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // key
	input  logic [0:0]  s_tuser,   // mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // status[2:0], position[10:3], zero fill
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] pos;
	} lookup_result_t;

	// private copy of the table and its size register
	logic [KEY_W-1:0]  slot_key  [MAX_SLOTS];
	logic              slot_used [MAX_SLOTS];
	logic [SIZE_W-1:0] size_reg;

	lookup_result_t expected_results [$];
	int             errs;

	// walk the table for one item and apply an insert to the private copy
	function automatic lookup_result_t probe_table(logic is_search, logic [KEY_W-1:0] key);
		int unsigned    span;
		int unsigned    slot;
		lookup_result_t r;
		if (size_reg == 0)
			span = 1;
		else if (size_reg > MAX_SLOTS)
			span = MAX_SLOTS;
		else
			span = 32'(size_reg);
		slot  = key % span;
		r.pos = '0;
		while (1) begin
			// bound is checked before any slot is looked at
			if (slot >= span) begin
				r.status = is_search ? ST_ABSENT_END : ST_NO_SPACE;
				return r;
			end
			if (!slot_used[slot[SLOT_W-1:0]]) begin
				if (is_search) begin
					r.status = ST_ABSENT_EMPTY;
				end else begin
					slot_key[slot[SLOT_W-1:0]]  = key;
					slot_used[slot[SLOT_W-1:0]] = 1'b1;
					r.status                    = ST_INSERTED;
					r.pos                       = POS_W'(slot);
				end
				return r;
			end
			if (slot_key[slot[SLOT_W-1:0]] == key) begin
				if (is_search) begin
					r.status = ST_FOUND;
					r.pos    = POS_W'(slot);
				end else begin
					r.status = ST_DUPLICATE;
				end
				return r;
			end
			slot++;
		end
		return r;
	endfunction

	// follow the channels, compare results in order
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		logic [STATUS_W-1:0] got_status;
		logic [POS_W-1:0]    got_pos;
		if (!arst_n) begin
			slot_used = '{default: 1'b0};
			size_reg = SIZE_RESET;
			expected_results.delete();
			errs = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			// result first: an item taken at the same edge is behind it
			if (m_tvalid && m_tready) begin
				got_status = m_tdata[2:0];
				got_pos    = m_tdata[10:3];
				if (expected_results.size() == 0) begin
					errs++;
					$display("%0t: unexpected result item, expected none, actual status %0d pos %0d",
						$time, got_status, got_pos);
				end else begin
					want = expected_results.pop_front();
					if (got_status !== want.status) begin
						errs++;
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, want.status, got_status);
					end
					if (got_pos !== want.pos) begin
						errs++;
						$display("%0t: position mismatch, expected %0d actual %0d",
							$time, want.pos, got_pos);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(probe_table(s_tuser[0], s_tdata));
			mismatches <= errs;
			pending    <= expected_results.size();
		end
	end

endmodule

@@ tb/sv/linear_probe_hash_table_tb.sv @@
// stimulus and verdict for the linear probing hash table
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;   // key
	logic [0:0]  s_tuser   = '0;   // mode
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // status[2:0], position[10:3], zero fill

	int mismatches;
	int pending;

	bit          tx_steady;
	bit          rx_steady;
	logic [31:0] key_pool [$];
	int          n_insert;
	int          n_search;
	int          n_size_writes;

	linear_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	lpht_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side back-pressure
	always begin
		int stall;
		stall = pick_gap(rx_steady);
		if (stall > 0) begin
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		m_tready <= 1'b1;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	end

	// offer one request item and hold it until taken
	task automatic send_item(logic mode, logic [31:0] key);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (mode == MODE_INSERT) begin
			n_insert++;
			key_pool.push_back(key);
			if (key_pool.size() > 64)
				void'(key_pool.pop_front());
		end else begin
			n_search++;
		end
	endtask

	// let every outstanding result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// size register write, only with the block idle
	task automatic write_size(logic [8:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_size_writes++;
	endtask

	// keys that hit stored entries, collide or land near the probe end
	function automatic logic [31:0] pick_key(int unsigned span);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4 && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r < 6)
			return $urandom();
		if (r < 8)
			return $urandom_range(0, 600);
		if (r < 9)
			return span * $urandom_range(0, 1000) + span - 1 - $urandom_range(0, 2);
		return 32'hFFFF_FFFF - $urandom_range(0, 300);
	endfunction

	function automatic logic [8:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 9'($urandom_range(2, 64));
		if (r < 8)
			return 9'($urandom_range(65, 256));
		if (r < 9)
			return 9'($urandom_range(257, 511));
		return 9'($urandom_range(0, 1));
	endfunction

	initial begin
		logic [8:0]  sizes [7];
		logic [8:0]  size_now;
		int unsigned span;
		int          burst;
		logic        mode;

		sizes     = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd257, 9'd255};
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full size after reset
		send_item(MODE_INSERT, 32'h0000_0000);
		send_item(MODE_INSERT, 32'hFFFF_FFFF);
		send_item(MODE_INSERT, 32'h0000_0000);
		send_item(MODE_SEARCH, 32'h0000_0000);
		send_item(MODE_SEARCH, 32'hFFFF_FFFF);
		send_item(MODE_SEARCH, 32'd7);
		send_item(MODE_INSERT, 32'd256);
		send_item(MODE_SEARCH, 32'd256);
		// collision on the last slot runs off the end
		send_item(MODE_INSERT, 32'd511);
		send_item(MODE_SEARCH, 32'd511);
		send_item(MODE_SEARCH, 32'd512);
		// zero size acts as one slot, stored entries stay
		write_size(9'd0);
		send_item(MODE_SEARCH, 32'd0);
		send_item(MODE_INSERT, 32'd5);
		send_item(MODE_SEARCH, 32'd5);
		// oversize clamps to the full table
		write_size(9'd511);
		send_item(MODE_SEARCH, 32'hFFFF_FFFF);
		send_item(MODE_INSERT, 32'h8000_0000);
		send_item(MODE_SEARCH, 32'h8000_0000);
		// shrunk table with entries above the new end
		write_size(9'd2);
		send_item(MODE_INSERT, 32'd3);
		send_item(MODE_SEARCH, 32'd256);
		send_item(MODE_SEARCH, 32'hFFFF_FFFF);

		// random phases: mostly inserts first, then mostly searches
		for (int phase = 0; phase < 15; phase++) begin
			size_now = (phase < 7) ? sizes[phase[2:0]] : pick_size();
			write_size(size_now);
			span = (size_now == 0) ? 1 :
				(size_now > MAX_SLOTS ? MAX_SLOTS : 32'(size_now));
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(22, 36);
			for (int i = 0; i < burst; i++) begin
				mode = ($urandom_range(0, 99) < ((i < burst / 2) ? 25 : 75)) ?
					MODE_SEARCH : MODE_INSERT;
				send_item(mode, pick_key(span));
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d inserts and %0d searches over %0d table size writes",
			n_insert, n_search, n_size_writes);
		$display("Sizes included zero, one, two, full, and values past the table end");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#15_000_000;
		$display("Timeout waiting for the block");
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ linear_probe_hash_table.f @@
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/lpht_mod.sv
hw/rtl/linear_probe_hash_table.sv
tb/sv/lpht_checker.sv
tb/sv/linear_probe_hash_table_tb.sv
